// File: rtl/bilinear_premultiplied_sampler_assert.svh
// assertion macros shared by the sampler checker
// depends on: a clk and an active-low rst_n in the scope of use
`ifndef BILINEAR_PREMULTIPLIED_SAMPLER_ASSERT_SVH
`define BILINEAR_PREMULTIPLIED_SAMPLER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sampler check failed");

// next-cycle implication, disabled in reset
`define BPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sampler check failed");

`endif

// File: rtl/bps_pkg.sv
// shared types, codes and constants of the bilinear sampler
// depends on: nothing
package bps_pkg;

    localparam int DIM_W   = 9;   // width of the size registers
    localparam int CRD_W   = 21;  // signed integer coordinate width
    localparam int KIND_W  = 3;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 8;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FORMAT = 2'd2;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        K_WRITE,
        K_READ,
        K_SAMPLE,
        K_BAD,
        K_ZERO
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_FETCH,
        S_DRAIN,
        S_DIV,
        S_OUT
    } state_t;

endpackage

// File: rtl/bps_ram.sv
// generic single-port ram with registered read
// depends on: nothing
module bps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/bps_queue.sv
// two-entry queue between the classifier and the execution unit
// depends on: nothing
module bps_queue #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/bps_front.sv
// command classifier: range checks, base address and neighbour mask
// depends on: bps_pkg
module bps_front #(
    parameter int ADDR_W    = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [7:0]                  pixel_x,
    input  logic [7:0]                  pixel_y,
    input  logic [7:0]                  red_in,
    input  logic [7:0]                  green_in,
    input  logic [7:0]                  blue_in,
    input  logic [7:0]                  alpha_in,
    input  logic signed [19:0]          sample_x,
    input  logic signed [19:0]          sample_y,
    input  logic [bps_pkg::DIM_W-1:0]   eff_w,
    input  logic [bps_pkg::DIM_W-1:0]   eff_h,
    input  logic                        fmt,
    input  logic                        q_full,
    output logic                        push,
    output bps_pkg::kind_t              kind,
    output logic [ADDR_W-1:0]           addr,
    output logic [3:0]                  inr,
    output logic [FRAC_BITS-1:0]        fx,
    output logic [FRAC_BITS-1:0]        fy,
    output logic [31:0]                 wdata
);
    import bps_pkg::*;

    logic signed [CRD_W-1:0] sx, sy, ix, iy, ix1, iy1, wlim, hlim;
    logic                    is_rw, xin0, xin1, yin0, yin1, empty;
    logic [ADDR_W-1:0]       ix_a, iy_a, w_a;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        sx    = CRD_W'(sample_x);
        sy    = CRD_W'(sample_y);
        is_rw = (cmd == CMD_WRITE) || (cmd == CMD_READ);
        ix    = is_rw ? signed'(CRD_W'(pixel_x)) : (sx >>> FRAC_BITS);
        iy    = is_rw ? signed'(CRD_W'(pixel_y)) : (sy >>> FRAC_BITS);
        ix1   = ix + CRD_W'(1);
        iy1   = iy + CRD_W'(1);
        wlim  = signed'(CRD_W'(eff_w));
        hlim  = signed'(CRD_W'(eff_h));
        xin0  = !ix[CRD_W-1]  && (ix  < wlim);
        xin1  = !ix1[CRD_W-1] && (ix1 < wlim);
        yin0  = !iy[CRD_W-1]  && (iy  < hlim);
        yin1  = !iy1[CRD_W-1] && (iy1 < hlim);
        empty = (eff_w == '0) || (eff_h == '0);
        inr   = {xin1 && yin1, xin0 && yin1, xin1 && yin0, xin0 && yin0};

        // modular base address, exact wherever the pixel lies inside
        ix_a  = ADDR_W'(ix);
        iy_a  = ADDR_W'(iy);
        w_a   = ADDR_W'(eff_w);
        addr  = iy_a * w_a + ix_a;

        fx    = sample_x[FRAC_BITS-1:0];
        fy    = sample_y[FRAC_BITS-1:0];
        wdata = fmt ? {alpha_in, blue_in, green_in, red_in} : {24'd0, red_in};

        unique case (cmd)
            CMD_WRITE:  kind = (xin0 && yin0) ? K_WRITE : K_BAD;
            CMD_READ:   kind = (xin0 && yin0) ? K_READ : K_BAD;
            CMD_SAMPLE: kind = empty ? K_ZERO : K_SAMPLE;
            default:    kind = K_ZERO;
        endcase
    end

endmodule

// File: rtl/bps_back.sv
// execution unit: pixel memory, weighted accumulation, rounding divider
// depends on: bps_pkg, bps_ram
module bps_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8,
    parameter int ADDR_W     = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  bps_pkg::kind_t              q_kind,
    input  logic [ADDR_W-1:0]           q_addr,
    input  logic [3:0]                  q_inr,
    input  logic [FRAC_BITS-1:0]        q_fx,
    input  logic [FRAC_BITS-1:0]        q_fy,
    input  logic [31:0]                 q_wdata,
    output logic                        q_pop,
    input  logic [bps_pkg::DIM_W-1:0]   eff_w,
    input  logic                        fmt,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  red_out,
    output logic [7:0]                  green_out,
    output logic [7:0]                  blue_out,
    output logic [7:0]                  alpha_out,
    output logic                        bad_access
);
    import bps_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int WW    = 2 * F + 1;
    localparam int PA_W  = 2 * F + 8;
    localparam int SUM_W = 2 * F + 16;
    localparam int NUM_W = 2 * F + 18;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [3:0]        inr_reg, inr_next;
    logic [F-1:0]      fx_reg, fx_next, fy_reg, fy_next;
    logic [1:0]        nb_reg, nb_next, p1_nb_reg, p1_nb_next;
    logic              p1_valid_reg, p1_valid_next, p2_valid_reg, p2_valid_next;
    logic [15:0]       ca_reg [3];
    logic [15:0]       ca_next [3];
    logic [7:0]        a_reg, a_next;
    logic [WW-1:0]     w_reg, w_next;
    logic [SUM_W-1:0]  acc_reg [3];
    logic [SUM_W-1:0]  acc_next [3];
    logic [PA_W-1:0]   pa_reg, pa_next;
    logic [NUM_W-1:0]  rem_reg [3];
    logic [NUM_W-1:0]  rem_next [3];
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [7:0]        quo_reg [3];
    logic [7:0]        quo_next [3];
    logic [2:0]        step_reg, step_next;
    logic [7:0]        res_reg [4];
    logic [7:0]        res_next [4];
    logic              res_bad_reg, res_bad_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_reg [4];
    logic              out_bad_reg, out_load;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       ram_rdata;
    logic [7:0]        dec_c [3];
    logic [7:0]        dec_a, s1_a;
    logic [7:0]        s1_c [3];
    logic              s1_in;
    logic [F:0]        wx, wy;
    logic [2*F+1:0]    wprod;
    logic [PA_W:0]     pa_round;
    logic              qbit;

    bps_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (q_wdata),
        .rdata (ram_rdata)
    );

    // pixel word to colour and alpha
    always_comb
    begin
        if (fmt)
        begin
            dec_c[0] = ram_rdata[7:0];
            dec_c[1] = ram_rdata[15:8];
            dec_c[2] = ram_rdata[23:16];
            dec_a    = ram_rdata[31:24];
        end
        else
        begin
            dec_c[0] = ram_rdata[7:0];
            dec_c[1] = ram_rdata[7:0];
            dec_c[2] = ram_rdata[7:0];
            dec_a    = 8'd255;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        inr_next      = inr_reg;
        fx_next       = fx_reg;
        fy_next       = fy_reg;
        nb_next       = nb_reg;
        p1_nb_next    = p1_nb_reg;
        p1_valid_next = 1'b0;
        pa_next       = pa_reg;
        dsh_next      = dsh_reg;
        step_next     = step_reg;
        res_bad_next  = res_bad_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_addr      = addr_reg;
        q_pop         = 1'b0;
        out_load      = 1'b0;
        qbit          = 1'b0;
        pa_round      = (PA_W+1)'(pa_reg) + ((PA_W+1)'(1) << (2 * F - 1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    addr_next = q_addr;
                    inr_next  = q_inr;
                    fx_next   = q_fx;
                    fy_next   = q_fy;
                    nb_next   = 2'd0;
                    pa_next   = '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        acc_next[k] = '0;
                    end
                    for (int k = 0; k < 4; k++)
                    begin
                        res_next[k] = 8'd0;
                    end
                    res_bad_next = 1'b0;
                    ram_addr     = q_addr;
                    case (q_kind)
                        K_WRITE:
                        begin
                            ram_we     = 1'b1;
                            state_next = S_OUT;
                        end
                        K_READ:   state_next = S_RD;
                        K_SAMPLE: state_next = S_FETCH;
                        K_BAD:
                        begin
                            res_bad_next = 1'b1;
                            state_next   = S_OUT;
                        end
                        default:  state_next = S_OUT;
                    endcase
                end
            end
            S_RD:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    res_next[k] = dec_c[k];
                end
                res_next[3] = dec_a;
                state_next  = S_OUT;
            end
            S_FETCH:
            begin
                // neighbour order: bit 0 steps x, bit 1 steps y
                ram_addr = addr_reg + (nb_reg[0] ? ADDR_W'(1) : '0)
                         + (nb_reg[1] ? ADDR_W'(eff_w) : '0);
                p1_valid_next = 1'b1;
                p1_nb_next    = nb_reg;
                nb_next       = nb_reg + 2'd1;
                if (nb_reg == 2'd3)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    if (pa_reg < (PA_W'(1) << (2 * F - 1)))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        // rounded quotient (2*sum + pa) / (2*pa), 8 bits
                        for (int k = 0; k < 3; k++)
                        begin
                            rem_next[k] = NUM_W'({acc_reg[k], 1'b0}) + NUM_W'(pa_reg);
                        end
                        dsh_next   = NUM_W'({pa_reg, 1'b0}) << 7;
                        step_next  = 3'd7;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    qbit = (rem_reg[k] >= dsh_reg);
                    rem_next[k] = qbit ? (rem_reg[k] - dsh_reg) : rem_reg[k];
                    quo_next[k] = {quo_reg[k][6:0], qbit};
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        res_next[k] = quo_next[k];
                    end
                    res_next[3] = pa_round[2*F+7:2*F];
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // stage 1: decode fetched neighbour, colour*alpha and weight
        s1_in = inr_reg[p1_nb_reg];
        s1_a  = s1_in ? dec_a : 8'd0;
        for (int k = 0; k < 3; k++)
        begin
            s1_c[k]    = s1_in ? dec_c[k] : 8'd0;
            ca_next[k] = s1_c[k] * s1_a;
        end
        wx     = p1_nb_reg[0] ? (F+1)'(fx_reg) : ((F+1)'(1) << F) - (F+1)'(fx_reg);
        wy     = p1_nb_reg[1] ? (F+1)'(fy_reg) : ((F+1)'(1) << F) - (F+1)'(fy_reg);
        wprod  = wx * wy;
        w_next = wprod[WW-1:0];
        a_next = s1_a;
        p2_valid_next = p1_valid_reg;

        // stage 2: accumulate weighted terms
        if (p2_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                acc_next[k] = acc_reg[k] + SUM_W'(ca_reg[k]) * SUM_W'(w_reg);
            end
            pa_next = pa_reg + PA_W'(a_reg) * PA_W'(w_reg);
        end

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        inr_reg     <= inr_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        nb_reg      <= nb_next;
        p1_nb_reg   <= p1_nb_next;
        ca_reg      <= ca_next;
        a_reg       <= a_next;
        w_reg       <= w_next;
        acc_reg     <= acc_next;
        pa_reg      <= pa_next;
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        res_reg     <= res_next;
        res_bad_reg <= res_bad_next;
        if (out_load)
        begin
            out_reg     <= res_reg;
            out_bad_reg <= res_bad_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = out_reg[0];
    assign green_out  = out_reg[1];
    assign blue_out   = out_reg[2];
    assign alpha_out  = out_reg[3];
    assign bad_access = out_bad_reg;

endmodule

// File: rtl/bilinear_premultiplied_sampler.sv
// bilinear premultiplied-alpha sampler over a gray8 / rgba8 pixel store
// flow: write, bad access and unused command go from idle to the output state, a read
//   through the read state; a sample skips the divider when the weighted alpha falls below one half
// throughput: one item at a time in the execution unit; a sample holds it through
//   4 single-port memory reads, 2 multiply stages and, when it divides, 8 divider steps
// a two-entry queue keeps the input open while a result waits at the output, until it is full
// reset: async active low; 256x256 rgba; pixel store is undefined until written
// depends on: bps_pkg, bps_front, bps_queue, bps_back
module bilinear_premultiplied_sampler #(
    parameter int MAX_WIDTH  = bps_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bps_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = bps_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [bps_pkg::DIM_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                cmd,
    input  logic [7:0]                pixel_x,
    input  logic [7:0]                pixel_y,
    input  logic [7:0]                red_in,
    input  logic [7:0]                green_in,
    input  logic [7:0]                blue_in,
    input  logic [7:0]                alpha_in,
    input  logic signed [19:0]        sample_x,
    input  logic signed [19:0]        sample_y,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                red_out,
    output logic [7:0]                green_out,
    output logic [7:0]                blue_out,
    output logic [7:0]                alpha_out,
    output logic                      bad_access
);
    import bps_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int QW     = KIND_W + ADDR_W + 4 + 2 * FRAC_BITS + 32;

    // configuration registers
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             fmt_reg, fmt_next;
    logic [DIM_W-1:0] eff_w, eff_h;

    // classifier outputs
    logic                 f_push;
    kind_t                f_kind;
    logic [ADDR_W-1:0]    f_addr;
    logic [3:0]           f_inr;
    logic [FRAC_BITS-1:0] f_fx, f_fy;
    logic [31:0]          f_wdata;

    // queue side
    logic                 q_full, q_valid, q_pop;
    logic [QW-1:0]        q_dout;
    logic [KIND_W-1:0]    q_kind_bits;
    kind_t                q_kind;
    logic [ADDR_W-1:0]    q_addr;
    logic [3:0]           q_inr;
    logic [FRAC_BITS-1:0] q_fx, q_fy;
    logic [31:0]          q_wdata;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        fmt_next    = fmt_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_next  = cfg_data;
                REG_HEIGHT: height_next = cfg_data;
                REG_FORMAT: fmt_next    = cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(256);
            height_reg <= DIM_W'(256);
            fmt_reg    <= 1'b1;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            fmt_reg    <= fmt_next;
        end
    end

    // sizes above the store limits act as the limits
    assign eff_w = (32'(width_reg)  > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : width_reg;
    assign eff_h = (32'(height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_reg;

    bps_front #(
        .ADDR_W    (ADDR_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .alpha_in (alpha_in),
        .sample_x (sample_x),
        .sample_y (sample_y),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .fmt      (fmt_reg),
        .q_full   (q_full),
        .push     (f_push),
        .kind     (f_kind),
        .addr     (f_addr),
        .inr      (f_inr),
        .fx       (f_fx),
        .fy       (f_fy),
        .wdata    (f_wdata)
    );

    // classified item transfer into the queue
    bps_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .din   ({f_kind, f_addr, f_inr, f_fx, f_fy, f_wdata}),
        .pop   (q_pop),
        .full  (q_full),
        .valid (q_valid),
        .dout  (q_dout)
    );

    assign {q_kind_bits, q_addr, q_inr, q_fx, q_fy, q_wdata} = q_dout;
    assign q_kind = kind_t'(q_kind_bits);

    bps_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_kind     (q_kind),
        .q_addr     (q_addr),
        .q_inr      (q_inr),
        .q_fx       (q_fx),
        .q_fy       (q_fy),
        .q_wdata    (q_wdata),
        .q_pop      (q_pop),
        .eff_w      (eff_w),
        .fmt        (fmt_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out),
        .bad_access (bad_access)
    );

endmodule

// File: rtl/bps_checker.sv
// port-level checks of the sampler, bound to the top level
// depends on: bilinear_premultiplied_sampler_assert.svh
`include "bilinear_premultiplied_sampler_assert.svh"

module bps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  cmd,
    input logic [7:0]  pixel_x,
    input logic [7:0]  pixel_y,
    input logic [7:0]  red_in,
    input logic [7:0]  green_in,
    input logic [7:0]  blue_in,
    input logic [7:0]  alpha_in,
    input logic [19:0] sample_x,
    input logic [19:0] sample_y,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  red_out,
    input logic [7:0]  green_out,
    input logic [7:0]  blue_out,
    input logic [7:0]  alpha_out,
    input logic        bad_access
);

    // a waiting command transfer keeps its payload
    `BPS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
        in_valid && $stable(cmd) && $stable(pixel_x) && $stable(pixel_y) && $stable(red_in)
        && $stable(green_in) && $stable(blue_in) && $stable(alpha_in) && $stable(sample_x)
        && $stable(sample_y))

    // a stalled result transfer keeps its red, alpha and bad-access outputs
    `BPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(red_out) && $stable(alpha_out) && $stable(bad_access))

    // a bad access carries an all-zero colour
    `BPS_ASSERT_NOW(a_bad_zero, out_valid && bad_access,
        red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0 && alpha_out == 8'd0)

    // no result can stand right after reset release
    `BPS_ASSERT_NOW(a_reset_clear, $rose(rst_n), !out_valid)

endmodule

bind bilinear_premultiplied_sampler bps_checker u_checker (.*);
